// File: hw/rtl/single_source_shortest_path_top_macros.svh
// Assertion helpers shared by sssp_dp and sssp_ctrl.
`ifndef SINGLE_SOURCE_SHORTEST_PATH_TOP_MACROS_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSSP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/sssp_pkg.sv
`timescale 1ns / 1ps
package sssp_pkg;

   localparam int MAX_NODES   = 1024;
   localparam int NODE_W      = 10;
   localparam int PRED_W      = NODE_W + 1;
   localparam int DIST_W      = 32;
   localparam int SOURCE_NODE = 1;
   localparam logic [DIST_W-1:0] DIST_INF = 32'h3F3F_3F3F;

   localparam int DEF_MAX_EDGES   = 4096;
   localparam int DEF_WEIGHT_BITS = 16;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic [NODE_W-1:0] TARGET_RESET = 10'd1;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_RUN   = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RSP_ZERO,
      RSP_FULL,
      RSP_NODE
   } rsp_sel_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_ADD_CHK,
      S_ADD_WR,
      S_ACK,
      S_FULL,
      S_CLEAR,
      S_RUN_CLR,
      S_SCAN,
      S_SETTLE,
      S_HEAD_LD,
      S_EDGE_RD,
      S_NODE_RD,
      S_RELAX,
      S_READ,
      S_REPORT
   } state_type;

   typedef struct packed {
      logic        accept;
      logic        ctr_clr;
      logic        ctr_inc;
      logic        head_clr_wr;
      logic        node_clr_wr;
      logic        run_clr;
      logic        cnt_clr;
      logic        add_head_rd;
      logic        add_wr;
      logic        scan_start;
      logic        scan_step;
      logic        settle;
      logic        head_ld;
      logic        edge_rd;
      logic        node_rd;
      logic        relax;
      logic        rpt_rd;
      logic        rpt_target;
      logic        load_rsp;
      rsp_sel_type rsp_sel;
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic scan_done;
      logic best_none;
      logic ptr_nil;
      logic edge_full;
      logic out_free;
   } sts_type;

endpackage

// File: hw/rtl/sssp_ram.sv
`timescale 1ns / 1ps
module sssp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/sssp_dp.sv
`timescale 1ns / 1ps
`include "single_source_shortest_path_top_macros.svh"
module sssp_dp #(
   parameter int MAX_EDGES   = sssp_pkg::DEF_MAX_EDGES,
   parameter int WEIGHT_BITS = sssp_pkg::DEF_WEIGHT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sssp_pkg::cmd_type             cmd,
   output sssp_pkg::sts_type             sts,
   input  logic [sssp_pkg::NODE_W-1:0]   req_from_node,
   input  logic [sssp_pkg::NODE_W-1:0]   req_to_node,
   input  logic [15:0]                   req_edge_weight,
   input  logic [sssp_pkg::NODE_W-1:0]   target_node,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sssp_pkg::DIST_W-1:0]   rsp_distance,
   output logic [sssp_pkg::PRED_W-1:0]   rsp_predecessor,
   output logic                          rsp_reachable,
   output logic                          rsp_status
);
   import sssp_pkg::*;

   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int LW  = $clog2(MAX_EDGES + 1);
   localparam int EW  = NODE_W + WEIGHT_BITS + LW;
   localparam int NVW = 1 + PRED_W + DIST_W;
   localparam int CW  = NODE_W + 1;
   localparam logic [LW-1:0]     LINK_NIL  = LW'(MAX_EDGES);
   localparam logic [PRED_W-1:0] PRED_NONE = PRED_W'(MAX_NODES);

   // counters and search registers
   logic [CW-1:0]          ctr_ff, ctr_in;
   logic                   pend_ff, pend_in;
   logic [NODE_W-1:0]      pidx_ff, pidx_in;
   logic [PRED_W-1:0]      best_ff, best_in;
   logic [DIST_W-1:0]      best_d_ff, best_d_in;
   logic [PRED_W-1:0]      best_pred_ff, best_pred_in;
   logic [LW-1:0]          edge_cnt_ff, edge_cnt_in;
   logic [LW-1:0]          edge_ptr_ff, edge_ptr_in;
   logic [NODE_W-1:0]      v_ff, v_in;
   logic [DIST_W:0]        nd_ff, nd_in;
   logic [NODE_W-1:0]      from_ff, from_in;
   logic [NODE_W-1:0]      to_ff, to_in;
   logic [WEIGHT_BITS-1:0] w_ff, w_in;
   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]      rsp_dist_ff, rsp_dist_in;
   logic [PRED_W-1:0]      rsp_pred_ff, rsp_pred_in;
   logic                   rsp_reach_ff, rsp_reach_in;
   logic                   rsp_stat_ff, rsp_stat_in;

   // RAM ports
   logic              head_we, head_re;
   logic [NODE_W-1:0] head_waddr, head_raddr;
   logic [LW-1:0]     head_wdata, head_rdata;
   logic              edge_we, edge_re;
   logic [EAW-1:0]    edge_waddr, edge_raddr;
   logic [EW-1:0]     edge_wdata, edge_rdata;
   logic              node_we, node_re;
   logic [NODE_W-1:0] node_waddr, node_raddr;
   logic [NVW-1:0]    node_wdata, node_rdata;

   logic                   nr_done;
   logic [PRED_W-1:0]      nr_pred;
   logic [DIST_W-1:0]      nr_dist;
   logic [NODE_W-1:0]      er_dest;
   logic [WEIGHT_BITS-1:0] er_cost;
   logic [LW-1:0]          er_link;
   logic                   ctr_at_end;
   logic                   scan_issue;
   logic                   out_free;

   sssp_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_head_ram (
      .clock(clock), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
      .re(head_re), .raddr(head_raddr), .rdata(head_rdata)
   );

   sssp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock(clock), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
      .re(edge_re), .raddr(edge_raddr), .rdata(edge_rdata)
   );

   sssp_ram #(.WIDTH(NVW), .DEPTH(MAX_NODES)) u_node_ram (
      .clock(clock), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
      .re(node_re), .raddr(node_raddr), .rdata(node_rdata)
   );

   assign nr_done = node_rdata[NVW-1];
   assign nr_pred = node_rdata[DIST_W +: PRED_W];
   assign nr_dist = node_rdata[DIST_W-1:0];
   assign er_dest = edge_rdata[EW-1 -: NODE_W];
   assign er_cost = edge_rdata[LW +: WEIGHT_BITS];
   assign er_link = edge_rdata[LW-1:0];

   assign ctr_at_end = (ctr_ff == CW'(MAX_NODES));
   assign scan_issue = cmd.scan_step && !ctr_at_end;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      sts.sweep_last = (ctr_ff == CW'(MAX_NODES - 1));
      sts.scan_done  = ctr_at_end && !pend_ff;
      sts.best_none  = (best_ff == PRED_NONE);
      sts.ptr_nil    = (edge_ptr_ff == LINK_NIL);
      sts.edge_full  = (edge_cnt_ff == LINK_NIL);
      sts.out_free   = out_free;
   end

   // RAM port steering
   always_comb begin
      head_we    = 1'b0;
      head_waddr = ctr_ff[NODE_W-1:0];
      head_wdata = LINK_NIL;
      head_re    = 1'b0;
      head_raddr = from_ff;
      if (cmd.head_clr_wr) begin
         head_we = 1'b1;
      end else if (cmd.add_wr) begin
         head_we    = 1'b1;
         head_waddr = from_ff;
         head_wdata = edge_cnt_ff;
      end
      if (cmd.add_head_rd) begin
         head_re = 1'b1;
      end else if (cmd.settle) begin
         head_re    = 1'b1;
         head_raddr = best_ff[NODE_W-1:0];
      end

      edge_we    = cmd.add_wr;
      edge_waddr = edge_cnt_ff[EAW-1:0];
      edge_wdata = {to_ff, w_ff, head_rdata};
      edge_re    = cmd.edge_rd;
      edge_raddr = edge_ptr_ff[EAW-1:0];

      node_we    = 1'b0;
      node_waddr = ctr_ff[NODE_W-1:0];
      node_wdata = {1'b0, PRED_NONE, DIST_INF};
      if (cmd.node_clr_wr) begin
         node_we = 1'b1;
         if (cmd.run_clr && ctr_ff == CW'(SOURCE_NODE)) begin
            node_wdata = {1'b0, PRED_NONE, {DIST_W{1'b0}}};
         end
      end else if (cmd.settle) begin
         node_we    = 1'b1;
         node_waddr = best_ff[NODE_W-1:0];
         node_wdata = {1'b1, best_pred_ff, best_d_ff};
      end else if (cmd.relax && nd_ff < {1'b0, nr_dist}) begin
         node_we    = 1'b1;
         node_waddr = v_ff;
         node_wdata = {nr_done, best_ff, nd_ff[DIST_W-1:0]};
      end

      node_re    = 1'b0;
      node_raddr = ctr_ff[NODE_W-1:0];
      if (scan_issue) begin
         node_re = 1'b1;
      end else if (cmd.node_rd) begin
         node_re    = 1'b1;
         node_raddr = er_dest;
      end else if (cmd.rpt_rd) begin
         node_re    = 1'b1;
         node_raddr = cmd.rpt_target ? target_node : from_ff;
      end
   end

   // next-state of the datapath registers
   always_comb begin
      ctr_in       = ctr_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      best_in      = best_ff;
      best_d_in    = best_d_ff;
      best_pred_in = best_pred_ff;
      edge_cnt_in  = edge_cnt_ff;
      edge_ptr_in  = edge_ptr_ff;
      v_in         = v_ff;
      nd_in        = nd_ff;
      from_in      = from_ff;
      to_in        = to_ff;
      w_in         = w_ff;

      if (cmd.accept) begin
         from_in = req_from_node;
         to_in   = req_to_node;
         w_in    = WEIGHT_BITS'(req_edge_weight);
      end

      if (cmd.ctr_clr || cmd.scan_start) begin
         ctr_in = '0;
      end else if (cmd.ctr_inc || scan_issue) begin
         ctr_in = ctr_ff + CW'(1);
      end

      if (cmd.scan_start) begin
         pend_in   = 1'b0;
         best_in   = PRED_NONE;
         best_d_in = DIST_INF;
      end else if (cmd.scan_step) begin
         pend_in = scan_issue;
         pidx_in = ctr_ff[NODE_W-1:0];
         if (pend_ff && !nr_done && nr_dist < best_d_ff) begin
            best_in      = PRED_W'(pidx_ff);
            best_d_in    = nr_dist;
            best_pred_in = nr_pred;
         end
      end

      if (cmd.cnt_clr) begin
         edge_cnt_in = '0;
      end else if (cmd.add_wr) begin
         edge_cnt_in = edge_cnt_ff + LW'(1);
      end

      if (cmd.head_ld) begin
         edge_ptr_in = head_rdata;
      end else if (cmd.node_rd) begin
         edge_ptr_in = er_link;
         v_in        = er_dest;
         nd_in       = {1'b0, best_d_ff} + (DIST_W + 1)'(er_cost);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_pred_in  = rsp_pred_ff;
      rsp_reach_in = rsp_reach_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         unique case (cmd.rsp_sel)
            RSP_NODE: begin
               rsp_dist_in  = nr_dist;
               rsp_pred_in  = nr_pred;
               rsp_reach_in = (nr_dist != DIST_INF);
               rsp_stat_in  = 1'b0;
            end
            RSP_FULL: begin
               rsp_dist_in  = '0;
               rsp_pred_in  = '0;
               rsp_reach_in = 1'b0;
               rsp_stat_in  = 1'b1;
            end
            default: begin
               rsp_dist_in  = '0;
               rsp_pred_in  = '0;
               rsp_reach_in = 1'b0;
               rsp_stat_in  = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff       <= '0;
         pend_ff      <= 1'b0;
         best_ff      <= PRED_NONE;
         best_d_ff    <= DIST_INF;
         edge_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctr_ff       <= ctr_in;
         pend_ff      <= pend_in;
         best_ff      <= best_in;
         best_d_ff    <= best_d_in;
         edge_cnt_ff  <= edge_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff      <= pidx_in;
      best_pred_ff <= best_pred_in;
      edge_ptr_ff  <= edge_ptr_in;
      v_ff         <= v_in;
      nd_ff        <= nd_in;
      from_ff      <= from_in;
      to_ff        <= to_in;
      w_ff         <= w_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_pred_ff  <= rsp_pred_in;
      rsp_reach_ff <= rsp_reach_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance    = rsp_dist_ff;
   assign rsp_predecessor = rsp_pred_ff;
   assign rsp_reachable   = rsp_reach_ff;
   assign rsp_status      = rsp_stat_ff;

   `SSSP_ASSERT_NOW(a_cnt_bound, 1'b1, edge_cnt_ff <= LINK_NIL, "edge count past store size")
   `SSSP_ASSERT_NOW(a_best_finite, best_ff != PRED_NONE, best_d_ff < DIST_INF, "chosen node has INF distance")
   `SSSP_ASSERT_NOW(a_load_free, cmd.load_rsp, out_free, "result loaded over an untaken word")

endmodule

// File: hw/rtl/sssp_ctrl.sv
`timescale 1ns / 1ps
`include "single_source_shortest_path_top_macros.svh"
module sssp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_op,
   input  sssp_pkg::sts_type sts,
   output sssp_pkg::cmd_type cmd
);
   import sssp_pkg::*;

   state_type state_ff, state_in;
   op_type    op_dec;

   assign op_dec = op_type'(req_op);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.head_clr_wr = 1'b1;
            cmd.node_clr_wr = 1'b1;
            cmd.ctr_inc     = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.ctr_clr = 1'b1;
            req_ready   = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               unique case (op_dec)
                  OP_ADD:   state_in = S_ADD_CHK;
                  OP_RUN:   state_in = S_RUN_CLR;
                  OP_READ:  state_in = S_READ;
                  OP_CLEAR: state_in = S_CLEAR;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_ADD_CHK: begin
            if (sts.edge_full) begin
               state_in = S_FULL;
            end else begin
               cmd.add_head_rd = 1'b1;
               state_in        = S_ADD_WR;
            end
         end
         S_ADD_WR: begin
            cmd.add_wr = 1'b1;
            state_in   = S_ACK;
         end
         S_ACK: begin
            if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_sel  = RSP_ZERO;
               state_in     = S_IDLE;
            end
         end
         S_FULL: begin
            if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_sel  = RSP_FULL;
               state_in     = S_IDLE;
            end
         end
         S_CLEAR: begin
            cmd.head_clr_wr = 1'b1;
            cmd.ctr_inc     = 1'b1;
            cmd.cnt_clr     = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_ACK;
            end
         end
         S_RUN_CLR: begin
            cmd.node_clr_wr = 1'b1;
            cmd.run_clr     = 1'b1;
            cmd.ctr_inc     = 1'b1;
            if (sts.sweep_last) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               if (sts.best_none) begin
                  cmd.rpt_rd     = 1'b1;
                  cmd.rpt_target = 1'b1;
                  state_in       = S_REPORT;
               end else begin
                  state_in = S_SETTLE;
               end
            end
         end
         S_SETTLE: begin
            cmd.settle = 1'b1;
            state_in   = S_HEAD_LD;
         end
         S_HEAD_LD: begin
            cmd.head_ld = 1'b1;
            state_in    = S_EDGE_RD;
         end
         S_EDGE_RD: begin
            if (sts.ptr_nil) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end else begin
               cmd.edge_rd = 1'b1;
               state_in    = S_NODE_RD;
            end
         end
         S_NODE_RD: begin
            cmd.node_rd = 1'b1;
            state_in    = S_RELAX;
         end
         S_RELAX: begin
            cmd.relax = 1'b1;
            state_in  = S_EDGE_RD;
         end
         S_READ: begin
            cmd.rpt_rd = 1'b1;
            state_in   = S_REPORT;
         end
         S_REPORT: begin
            if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_sel  = RSP_NODE;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `SSSP_ASSERT_NEXT(a_accept_busy, req_valid && req_ready, state_ff != S_IDLE, "accepted word left block idle")
   `SSSP_ASSERT_NOW(a_ready_idle, req_ready, state_ff == S_IDLE, "ready outside idle")
   `SSSP_ASSERT_NOW(a_single_rd, cmd.scan_step, !cmd.rpt_rd || sts.scan_done, "report read during scan")

endmodule

// File: hw/rtl/single_source_shortest_path_top.sv
`timescale 1ns / 1ps
// Dijkstra shortest paths from node 1 over a stored directed graph. Send a word with
// op 0 to append an edge (from_node -> to_node, edge_weight), op 1 to run a search and
// get the distance, predecessor and reachability of the node in the target_node
// register, op 2 to read one node's last search result (for path tracing) and op 3 to
// empty the graph. Every word gives exactly one result word; status is set only when an
// edge finds the store full. Unreached nodes read 0x3F3F3F3F with predecessor 1024.
// After reset the block sweeps its adjacency heads and node table with req_ready low. A
// search first resets the node table, then for each reachable node runs one linear scan
// of the node table (one RAM read per node), settles that node and relaxes each of its
// outgoing edges, and ends with one last scan; the scan is bound by the node table's
// single read port. The user must write configuration over the APB port only while the
// block is idle; the block itself does not enforce this.
module single_source_shortest_path_top #(
   parameter int MAX_EDGES   = sssp_pkg::DEF_MAX_EDGES,
   parameter int WEIGHT_BITS = sssp_pkg::DEF_WEIGHT_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   // request words
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_op,
   input  logic [sssp_pkg::NODE_W-1:0] req_from_node,
   input  logic [sssp_pkg::NODE_W-1:0] req_to_node,
   input  logic [15:0]                 req_edge_weight,
   // result words
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [sssp_pkg::DIST_W-1:0] rsp_distance,
   output logic [sssp_pkg::PRED_W-1:0] rsp_predecessor,
   output logic                        rsp_reachable,
   output logic                        rsp_status,
   // register port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sssp_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [sssp_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [sssp_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import sssp_pkg::*;

   cmd_type           cmd;
   sts_type           sts;
   logic [NODE_W-1:0] target_ff, target_in;
   logic              target_hit;

   // Only one register: target_node at byte 0; word index is paddr bit 2.
   assign target_hit = !csr_paddr[CSR_AW-1];
   assign csr_pready = 1'b1;
   assign csr_prdata = target_hit ? CSR_DW'(target_ff) : '0;

   always_comb begin
      target_in = target_ff;
      if (csr_psel && csr_penable && csr_pwrite && target_hit) begin
         target_in = csr_pwdata[NODE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
      end else begin
         target_ff <= target_in;
      end
   end

   // Sequencer: one word at a time, steps the datapath by commands.
   sssp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: adjacency, edge and node RAMs, min scan, relax, output register.
   sssp_dp #(
      .MAX_EDGES   (MAX_EDGES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_from_node   (req_from_node),
      .req_to_node     (req_to_node),
      .req_edge_weight (req_edge_weight),
      .target_node     (target_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_distance    (rsp_distance),
      .rsp_predecessor (rsp_predecessor),
      .rsp_reachable   (rsp_reachable),
      .rsp_status      (rsp_status)
   );

endmodule
